### design/srws_pkg.sv
`default_nettype none

package srws_pkg;

    localparam int MAX_SECTORS_DEF = 256;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int QUIET_W    = 16;
    localparam int SECT_CFG_W = 9;
    localparam int IDX_W      = 8;
    localparam int STAT_W     = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SAVE_ENABLED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUIET_FRAMES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECTOR_COUNT = 2'd2;

    localparam logic [QUIET_W-1:0]    QUIET_RESET  = 16'd60;
    localparam logic [SECT_CFG_W-1:0] SECTOR_RESET = 9'd1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;

    typedef enum logic [2:0] {
        CMD_NONE     = 3'd0,
        CMD_SNAPSHOT = 3'd1,
        CMD_BEGIN    = 3'd2,
        CMD_SECTOR   = 3'd3,
        CMD_END      = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_BEGIN  = 2'd1,
        PH_SECTOR = 2'd2,
        PH_END    = 2'd3
    } phase_t;

    typedef struct packed {
        logic                  save_enabled;
        logic [QUIET_W-1:0]    quiet_frames;
        logic [SECT_CFG_W-1:0] sector_count;
    } cfg_t;

    typedef struct packed {
        cmd_t              command;
        logic [IDX_W-1:0]  sector_index;
        logic              writing;
        logic [STAT_W-1:0] save_count;
        logic [STAT_W-1:0] error_count;
        logic [STAT_W-1:0] busy_count;
        logic [STAT_W-1:0] last_save_len;
    } result_t;

endpackage

`default_nettype wire

### design/srws_cfg.sv
`default_nettype none

module srws_cfg
    import srws_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_SAVE_ENABLED: cfg_next.save_enabled = cfg_wdata[0];
                REG_QUIET_FRAMES: cfg_next.quiet_frames = cfg_wdata[QUIET_W-1:0];
                REG_SECTOR_COUNT: cfg_next.sector_count = cfg_wdata[SECT_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.save_enabled <= 1'b0;
            cfg_reg.quiet_frames <= QUIET_RESET;
            cfg_reg.sector_count <= SECTOR_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### design/srws_core.sv
`default_nettype none

module srws_core
    import srws_pkg::*;
#(
    parameter int MAX_SECTORS = MAX_SECTORS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step,
    input  wire logic       ram_changed,
    input  wire logic [1:0] storage_status,
    input  wire cfg_t       cfg,
    output result_t         res
);

    localparam int CNT_W = $clog2(MAX_SECTORS + 1);
    localparam int CMP_W = (CNT_W > SECT_CFG_W) ? CNT_W : SECT_CFG_W;
    localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_SECTORS);

    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  sector_reg, sector_next;
    logic [STAT_W-1:0] frame_reg, frame_next;
    logic [STAT_W-1:0] change_reg, change_next;
    logic [STAT_W-1:0] start_reg, start_next;
    logic              dirty_reg, dirty_next;
    logic              writing_reg, writing_next;
    logic [STAT_W-1:0] saves_reg, saves_next;
    logic [STAT_W-1:0] errors_reg, errors_next;
    logic [STAT_W-1:0] busy_reg, busy_next;
    logic [STAT_W-1:0] length_reg, length_next;

    logic              st_ok, st_busy, st_err, issued;
    logic              dirty_pre, save_go, last_sector;
    logic [STAT_W-1:0] change_pre;
    logic [CMP_W-1:0]  sc_ext, sc_min1, eff_sectors;
    logic [CNT_W-1:0]  sector_inc;
    cmd_t              cmd;
    logic [IDX_W-1:0]  idx;

    assign st_ok   = (storage_status == ST_OK);
    assign st_busy = (storage_status == ST_BUSY);
    assign st_err  = storage_status[1];
    assign issued  = cfg.save_enabled && (phase_reg != PH_IDLE);

    assign frame_next = frame_reg + 32'd1;
    assign dirty_pre  = ram_changed ? 1'b1 : dirty_reg;
    assign change_pre = ram_changed ? frame_next : change_reg;
    assign save_go    = dirty_pre &&
                        ((frame_next - change_pre) >= {16'd0, cfg.quiet_frames});

    assign sc_ext      = CMP_W'(cfg.sector_count);
    assign sc_min1     = (sc_ext == '0) ? CMP_W'(1) : sc_ext;
    assign eff_sectors = (sc_min1 > MAX_CMP) ? MAX_CMP : sc_min1;
    assign sector_inc  = sector_reg + CNT_W'(1);
    assign last_sector = (CMP_W'(sector_inc) >= eff_sectors);

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (cfg.save_enabled) begin
            case (phase_reg)
                PH_IDLE:   if (save_go) phase_next = PH_BEGIN;
                PH_BEGIN:  if (st_ok) phase_next = PH_SECTOR;
                PH_SECTOR: if (st_ok && last_sector) phase_next = PH_END;
                PH_END:    if (st_ok) phase_next = PH_IDLE;
                default:   phase_next = PH_IDLE;
            endcase
            if (issued && st_err) begin
                phase_next = PH_IDLE;
            end
        end
    end

    // command and datapath
    always_comb begin
        cmd          = CMD_NONE;
        idx          = '0;
        sector_next  = sector_reg;
        change_next  = change_reg;
        start_next   = start_reg;
        dirty_next   = dirty_reg;
        writing_next = writing_reg;
        saves_next   = saves_reg;
        errors_next  = errors_reg;
        busy_next    = busy_reg;
        length_next  = length_reg;
        if (cfg.save_enabled) begin
            dirty_next  = dirty_pre;
            change_next = change_pre;
            case (phase_reg)
                PH_IDLE: begin
                    if (save_go) begin
                        cmd          = CMD_SNAPSHOT;
                        dirty_next   = 1'b0;
                        start_next   = frame_next;
                        writing_next = 1'b1;
                    end
                end
                PH_BEGIN: begin
                    cmd = CMD_BEGIN;
                    if (st_ok) sector_next = '0;
                end
                PH_SECTOR: begin
                    cmd = CMD_SECTOR;
                    idx = sector_reg[IDX_W-1:0];
                    if (st_ok) sector_next = sector_inc;
                end
                default: begin
                    cmd = CMD_END;
                    if (st_ok) begin
                        writing_next = 1'b0;
                        saves_next   = saves_reg + 32'd1;
                        length_next  = frame_next - start_reg;
                    end
                end
            endcase
            if (issued && st_busy) begin
                busy_next = busy_reg + 32'd1;
            end
            if (issued && st_err) begin
                errors_next  = errors_reg + 32'd1;
                writing_next = 1'b0;
                dirty_next   = 1'b1;
                change_next  = frame_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            sector_reg  <= '0;
            frame_reg   <= '0;
            change_reg  <= '0;
            start_reg   <= '0;
            dirty_reg   <= 1'b0;
            writing_reg <= 1'b0;
            saves_reg   <= '0;
            errors_reg  <= '0;
            busy_reg    <= '0;
            length_reg  <= '0;
        end else if (step) begin
            phase_reg   <= phase_next;
            sector_reg  <= sector_next;
            frame_reg   <= frame_next;
            change_reg  <= change_next;
            start_reg   <= start_next;
            dirty_reg   <= dirty_next;
            writing_reg <= writing_next;
            saves_reg   <= saves_next;
            errors_reg  <= errors_next;
            busy_reg    <= busy_next;
            length_reg  <= length_next;
        end
    end

    always_comb begin
        res.command       = cmd;
        res.sector_index  = idx;
        res.writing       = writing_next;
        res.save_count    = saves_next;
        res.error_count   = errors_next;
        res.busy_count    = busy_next;
        res.last_save_len = length_next;
    end

endmodule

`default_nettype wire

### design/save_ram_writeback_sequencer.sv
// Save-RAM writeback sequencer. Each input beat is one frame tick: a RAM-changed
// flag and the status of the storage command issued on that tick. Each tick
// yields exactly one result beat: the command for this tick, the sector index
// and the save statistics. One beat is taken per cycle while the output is not
// stalled by m_ready; a tick passes through an input register and the sequencer
// logic into the result register. Write configuration only while no ticks are in
// flight.
`default_nettype none

module save_ram_writeback_sequencer
    import srws_pkg::*;
#(
    parameter int MAX_SECTORS = MAX_SECTORS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_ram_changed,
    input  wire logic [1:0]            s_storage_status,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [2:0]                 m_command,
    output logic [IDX_W-1:0]           m_sector_index,
    output logic                       m_writing,
    output logic [STAT_W-1:0]          m_save_count,
    output logic [STAT_W-1:0]          m_error_count,
    output logic [STAT_W-1:0]          m_busy_count,
    output logic [STAT_W-1:0]          m_last_save_len
);

    cfg_t    cfg;
    result_t res;
    result_t out_reg;

    logic       in_valid_reg, in_valid_next;
    logic       out_valid_reg, out_valid_next;
    logic       changed_reg;
    logic [1:0] status_reg;
    logic       advance, step, in_fire;

    srws_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    srws_core #(
        .MAX_SECTORS (MAX_SECTORS)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (step),
        .ram_changed    (changed_reg),
        .storage_status (status_reg),
        .cfg            (cfg),
        .res            (res)
    );

    assign advance = !out_valid_reg || m_ready;
    assign step    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign in_fire = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_fire) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (step) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            changed_reg <= s_ram_changed;
            status_reg  <= s_storage_status;
        end
        if (step) begin
            out_reg <= res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_command       = out_reg.command;
    assign m_sector_index  = out_reg.sector_index;
    assign m_writing       = out_reg.writing;
    assign m_save_count    = out_reg.save_count;
    assign m_error_count   = out_reg.error_count;
    assign m_busy_count    = out_reg.busy_count;
    assign m_last_save_len = out_reg.last_save_len;

endmodule

`default_nettype wire
